### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check expr at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: check failed");

// Check that cons holds on the edge after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### rtl/twlkd_pkg.sv
// Types, codes and decode functions of the two-wire LED and key driver master.
`timescale 1ns / 1ps
package twlkd_pkg;

	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_DISPLAY    = 2'd1;
	localparam logic [1:0] OP_BRIGHTNESS = 2'd2;
	localparam logic [1:0] OP_READ_KEYS  = 2'd3;

	localparam logic [2:0] SEG_START = 3'd0;
	localparam logic [2:0] SEG_W44   = 3'd1;
	localparam logic [2:0] SEG_WADDR = 3'd2;
	localparam logic [2:0] SEG_WDATA = 3'd3;
	localparam logic [2:0] SEG_ACK   = 3'd4;
	localparam logic [2:0] SEG_READ  = 3'd5;
	localparam logic [2:0] SEG_STOP  = 3'd6;
	localparam logic [2:0] SEG_END   = 3'd7;

	localparam logic [7:0] CMD_AUTO_WRITE = 8'h44;
	localparam logic [7:0] CMD_READ_KEYS  = 8'h42;
	localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
	localparam logic [7:0] CMD_DISP_ON    = 8'h88;
	localparam logic [7:0] CMD_DISP_OFF   = 8'h80;

	localparam logic [7:0] KEY_NONE_RAW = 8'hFF;
	localparam logic [7:0] KEY1_RAW     = 8'hF7;
	localparam logic [7:0] KEY2_RAW     = 8'hF6;
	localparam logic [7:0] KEY3_RAW     = 8'hF5;
	localparam logic [7:0] KEY4_RAW     = 8'hF4;
	localparam logic [7:0] KEY5_RAW     = 8'hF3;

	localparam logic [2:0] KEY_NONE    = 3'd0;
	localparam logic [2:0] KEY_UNKNOWN = 3'd6;

	typedef struct packed {
		logic       data_line_in;
		logic [3:0] brightness_level;
		logic [7:0] segment_pattern;
		logic [2:0] digit_position;
		logic [1:0] operation;
	} item_t;

	typedef struct packed {
		logic [2:0] key_code;
		logic       key_ready;
		logic       command_taken;
		logic       busy_res;
		logic       data_line_out;
		logic       clock_line;
	} result_t;

	typedef struct packed {
		logic [2:0] seg;
		logic [4:0] off;
		logic       last;
	} phase_t;

	function automatic logic [2:0] decode_key(input logic [7:0] v);
		logic [2:0] k;
		unique case (v)
			KEY_NONE_RAW: k = KEY_NONE;
			KEY1_RAW:     k = 3'd1;
			KEY2_RAW:     k = 3'd2;
			KEY3_RAW:     k = 3'd3;
			KEY4_RAW:     k = 3'd4;
			KEY5_RAW:     k = 3'd5;
			default:      k = KEY_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic phase_t phase_decode(input logic [1:0] kind, input logic [6:0] p);
		phase_t r;
		logic [6:0] base;
		r.seg = SEG_END;
		r.last = 1'b0;
		base = 7'd0;
		unique case (kind)
			OP_DISPLAY: begin
				if (p < 7'd3) begin
					r.seg = SEG_START; base = 7'd0;
				end else if (p < 7'd19) begin
					r.seg = SEG_W44; base = 7'd3;
				end else if (p < 7'd21) begin
					r.seg = SEG_ACK; base = 7'd19;
				end else if (p < 7'd24) begin
					r.seg = SEG_STOP; base = 7'd21;
				end else if (p < 7'd27) begin
					r.seg = SEG_START; base = 7'd24;
				end else if (p < 7'd43) begin
					r.seg = SEG_WADDR; base = 7'd27;
				end else if (p < 7'd45) begin
					r.seg = SEG_ACK; base = 7'd43;
				end else if (p < 7'd61) begin
					r.seg = SEG_WDATA; base = 7'd45;
				end else if (p < 7'd63) begin
					r.seg = SEG_ACK; base = 7'd61;
				end else begin
					r.seg = SEG_STOP; base = 7'd63;
				end
				r.last = (p >= 7'd65);
			end
			OP_BRIGHTNESS: begin
				if (p < 7'd3) begin
					r.seg = SEG_START; base = 7'd0;
				end else if (p < 7'd19) begin
					r.seg = SEG_WADDR; base = 7'd3;
				end else if (p < 7'd21) begin
					r.seg = SEG_ACK; base = 7'd19;
				end else begin
					r.seg = SEG_STOP; base = 7'd21;
				end
				r.last = (p >= 7'd23);
			end
			OP_READ_KEYS: begin
				if (p < 7'd3) begin
					r.seg = SEG_START; base = 7'd0;
				end else if (p < 7'd19) begin
					r.seg = SEG_WADDR; base = 7'd3;
				end else if (p < 7'd21) begin
					r.seg = SEG_ACK; base = 7'd19;
				end else if (p < 7'd37) begin
					r.seg = SEG_READ; base = 7'd21;
				end else if (p < 7'd39) begin
					r.seg = SEG_ACK; base = 7'd37;
				end else begin
					r.seg = SEG_STOP; base = 7'd39;
				end
				r.last = (p >= 7'd41);
			end
			default: begin
				r.seg = SEG_END;
				r.last = 1'b1;
			end
		endcase
		r.off = 5'(p - base);
		return r;
	endfunction

endpackage

### rtl/twlkd_core.sv
// Transaction state and pin sequencer; advances one item when enabled.
`timescale 1ns / 1ps
module twlkd_core import twlkd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t res
);

	logic       clock_q, data_q;
	logic [6:0] step_q;
	logic [1:0] kind_q;
	logic [7:0] addr_q, dbyte_q, shift_q;
	logic [2:0] key_q;

	logic       clock_d, data_d;
	logic [6:0] step_d;
	logic [1:0] kind_d;
	logic [7:0] addr_d, dbyte_d, shift_d;
	logic [2:0] key_d;
	logic       taken, ready;
	phase_t     ph;
	logic [7:0] tx_byte;
	logic [3:0] lvl;

	always_comb begin
		ph = phase_decode(kind_q, 7'(step_q - 7'd1));
		lvl = (item.brightness_level > 4'd8) ? 4'd8 : item.brightness_level;
		clock_d = clock_q;
		data_d  = data_q;
		step_d  = step_q;
		kind_d  = kind_q;
		addr_d  = addr_q;
		dbyte_d = dbyte_q;
		shift_d = shift_q;
		key_d   = key_q;
		taken   = 1'b0;
		ready   = 1'b0;
		case (ph.seg)
			SEG_W44: tx_byte = CMD_AUTO_WRITE;
			SEG_WADDR: tx_byte = addr_q;
			default: tx_byte = dbyte_q;
		endcase
		if (item.operation == OP_TICK) begin
			if (step_q != 7'd0) begin
				case (ph.seg)
					SEG_START: begin
						clock_d = (ph.off < 5'd2);
						data_d  = (ph.off == 5'd0);
					end
					SEG_STOP: begin
						clock_d = (ph.off != 5'd0);
						data_d  = (ph.off == 5'd2);
					end
					SEG_ACK: begin
						clock_d = ph.off[0];
						data_d  = 1'b1;
					end
					SEG_READ: begin
						clock_d = ph.off[0];
						data_d  = 1'b1;
						if (ph.off[0])
							shift_d = {item.data_line_in, shift_q[7:1]};
					end
					SEG_W44, SEG_WADDR, SEG_WDATA: begin
						clock_d = ph.off[0];
						data_d  = tx_byte[ph.off[3:1]];
					end
					default: ;
				endcase
				if (ph.last) begin
					step_d = 7'd0;
					if (kind_q == OP_READ_KEYS) begin
						key_d = decode_key(shift_q);
						ready = 1'b1;
					end
				end else begin
					step_d = 7'(step_q + 7'd1);
				end
			end
		end else if (step_q == 7'd0) begin
			unique case (item.operation)
				OP_DISPLAY: begin
					if (item.digit_position >= 3'd1 && item.digit_position <= 3'd6) begin
						addr_d  = CMD_ADDR_BASE | {5'd0, 3'(item.digit_position - 3'd1)};
						dbyte_d = item.segment_pattern;
						taken   = 1'b1;
					end
				end
				OP_BRIGHTNESS: begin
					addr_d = (lvl == 4'd0) ? CMD_DISP_OFF
						: (CMD_DISP_ON | {5'd0, 3'(lvl - 4'd1)});
					taken  = 1'b1;
				end
				default: begin
					addr_d  = CMD_READ_KEYS;
					shift_d = 8'd0;
					taken   = 1'b1;
				end
			endcase
			if (taken) begin
				kind_d = item.operation;
				step_d = 7'd1;
			end
		end
		res.clock_line    = clock_d;
		res.data_line_out = data_d;
		res.busy_res      = (step_d != 7'd0);
		res.command_taken = taken;
		res.key_ready     = ready;
		res.key_code      = key_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= 1'b1;
			data_q  <= 1'b1;
			step_q  <= 7'd0;
			kind_q  <= OP_TICK;
			addr_q  <= 8'd0;
			dbyte_q <= 8'd0;
			shift_q <= 8'd0;
			key_q   <= KEY_NONE;
		end else if (en) begin
			clock_q <= clock_d;
			data_q  <= data_d;
			step_q  <= step_d;
			kind_q  <= kind_d;
			addr_q  <= addr_d;
			dbyte_q <= dbyte_d;
			shift_q <= shift_d;
			key_q   <= key_d;
		end
	end

endmodule

### rtl/two_wire_led_key_driver_master.sv
// Top level of the two-wire LED and key driver master.
//
// Input stream: each transaction is either a bus tick (tuser = 0) or a command
// (tuser = 1 display digit, 2 set brightness, 3 read keys). A command is taken
// only while no bus sequence runs; each tick then drives one pin phase:
// start, LSB-first bytes with an acknowledge clock, stop.
// Output stream: exactly one result transaction per input transaction, with
// the pin levels, busy, command_taken, key_ready and the last key code.
// An accepted input reaches result valid through the input register, then the
// result register. Throughput: one transaction per cycle unless the result
// receiver stalls; the phase decode and state update between them are combinational.
// Reset: pins idle high, no sequence running, key code 0, both registers empty.
// Stall: when the result receiver holds tready low, the result register holds
// its transaction and the input register keeps one more; further input is
// then refused until the output drains.
`timescale 1ns / 1ps
module two_wire_led_key_driver_master import twlkd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata, // digit_position, segment_pattern, brightness_level, data_line_in
	input  logic [1:0]  s_axis_tuser, // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata  // clock_line, data_line_out, busy_res, command_taken, key_ready, key_code
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t core_res;
	logic    advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation        <= s_axis_tuser;
			item_s1.digit_position   <= s_axis_tdata[2:0];
			item_s1.segment_pattern  <= s_axis_tdata[10:3];
			item_s1.brightness_level <= s_axis_tdata[14:11];
			item_s1.data_line_in     <= s_axis_tdata[15];
		end
	end

	twlkd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= core_res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

endmodule

### rtl/twlkd_checker.sv
// Port-level checks of the two-wire LED and key driver master, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module twlkd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	`ASSERT_ALWAYS(a_taken_busy, clk, arst_n, !(m_axis_tvalid && m_axis_tdata[3]) || m_axis_tdata[2])
	`ASSERT_ALWAYS(a_ready_idle, clk, arst_n, !(m_axis_tvalid && m_axis_tdata[4]) || !m_axis_tdata[2])
	`ASSERT_ALWAYS(a_taken_pins_idle, clk, arst_n, !(m_axis_tvalid && m_axis_tdata[3]) || (m_axis_tdata[0] && m_axis_tdata[1]))
	`ASSERT_ALWAYS(a_key_range, clk, arst_n, !m_axis_tvalid || (m_axis_tdata[7:5] != 3'd7))
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind two_wire_led_key_driver_master twlkd_checker u_twlkd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
